// File: hw/rtl/cmpb_pkg.sv
// ----------------------------------------------------------------------------
// cmpb_pkg: shared types and constants for the color mask pixel blend
// Pixel transaction structs, configuration register indexes and the
// blend mode codes used by the pipeline.
// ----------------------------------------------------------------------------
package cmpb_pkg;

    localparam int CHAN_W     = 8;
    localparam int COV_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = 16;   // paint*c and old*(256-c) never exceed 65280
    localparam int NUM_CHAN   = 4;    // alpha, red, green, blue

    localparam logic [COV_W-1:0]  FULL_COV = 9'd256;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Channel lanes inside the pipeline
    localparam int LANE_A = 0;
    localparam int LANE_R = 1;
    localparam int LANE_G = 2;
    localparam int LANE_B = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_RED   = 3'd0,
        REG_TARGET_GREEN = 3'd1,
        REG_TARGET_BLUE  = 3'd2,
        REG_TARGET_ALPHA = 3'd3
    } t_cfg_idx;

    // Blend mode chosen per pixel
    typedef enum logic [1:0] {
        MODE_FULL  = 2'd0,   // paint color replaces the pixel
        MODE_PASS  = 2'd1,   // pixel passes unchanged
        MODE_CLEAR = 2'd2,   // transparent pixel: paint color, scaled alpha
        MODE_MIX   = 2'd3    // linear mix of every channel
    } t_mode;

    typedef struct packed {
        logic [COV_W-1:0]  coverage;
        logic [CHAN_W-1:0] in_alpha;
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
    } t_pix_in;

    typedef struct packed {
        logic [CHAN_W-1:0] out_alpha;
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
    } t_pix_out;

endpackage

// File: hw/rtl/color_mask_pixel_blend.sv
// ----------------------------------------------------------------------------
// color_mask_pixel_blend: paint a fixed color over an ARGB8 pixel by coverage
// Three-stage pipeline: classify and saturate, multiply, sum and select.
// ----------------------------------------------------------------------------
// Takes one pixel transaction per clock (busy stays low) and presents its
// result on o_pix with o_strobe high after the three register stages, for
// one cycle only; the receiver must take it then, as the pipeline has no
// stall path. The three register stages are input classification, the
// eight 8x9 multiplies, and the final add and select.
// Write the target color registers only while no pixel is in flight.
module color_mask_pixel_blend
    import cmpb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel input
    input  logic                 start,
    output logic                 busy,
    input  t_pix_in              i_pix,
    // pixel result
    output logic                 o_strobe,
    output t_pix_out             o_pix,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CHAN_W-1:0]    i_cfg_data
);

    logic [CHAN_W-1:0] r_tgt_red, r_tgt_green, r_tgt_blue, r_tgt_alpha;

    logic              r_s1_vld;
    t_mode             r_s1_mode, n_s1_mode;
    logic [COV_W-1:0]  r_s1_c, n_s1_c;
    logic [COV_W-1:0]  r_s1_inv;
    t_pix_in           r_s1_pix;

    logic              r_s2_vld;
    t_mode             r_s2_mode;
    t_pix_in           r_s2_pix;
    logic [PROD_W-1:0] r_s2_pa [NUM_CHAN];
    logic [PROD_W-1:0] r_s2_po [NUM_CHAN];
    logic [CHAN_W-1:0] n_paint [NUM_CHAN];
    logic [CHAN_W-1:0] n_old   [NUM_CHAN];

    logic              r_o_vld;
    t_pix_out          r_o_pix, n_o_pix;
    logic [CHAN_W-1:0] n_mix   [NUM_CHAN];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Configuration registers: ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_red   <= '0;
            r_tgt_green <= '0;
            r_tgt_blue  <= '0;
            r_tgt_alpha <= CHAN_MAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_TARGET_RED:   r_tgt_red   <= i_cfg_data;
                REG_TARGET_GREEN: r_tgt_green <= i_cfg_data;
                REG_TARGET_BLUE:  r_tgt_blue  <= i_cfg_data;
                REG_TARGET_ALPHA: r_tgt_alpha <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: saturate coverage and pick the blend mode
    always_comb begin
        n_s1_c = (i_pix.coverage >= FULL_COV) ? FULL_COV : i_pix.coverage;
        priority if (n_s1_c == FULL_COV) begin
            n_s1_mode = MODE_FULL;
        end else if (n_s1_c == '0) begin
            n_s1_mode = MODE_PASS;
        end else if (i_pix.in_alpha == '0) begin
            n_s1_mode = MODE_CLEAR;
        end else begin
            n_s1_mode = MODE_MIX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_c    <= n_s1_c;
        r_s1_inv  <= FULL_COV - n_s1_c;
        r_s1_mode <= n_s1_mode;
        r_s1_pix  <= i_pix;
    end

    // Stage 2: paint*c and old*(256-c) for each lane
    always_comb begin
        n_paint[LANE_A] = CHAN_MAX;
        n_paint[LANE_R] = r_tgt_red;
        n_paint[LANE_G] = r_tgt_green;
        n_paint[LANE_B] = r_tgt_blue;
        n_old[LANE_A]   = r_s1_pix.in_alpha;
        n_old[LANE_R]   = r_s1_pix.in_red;
        n_old[LANE_G]   = r_s1_pix.in_green;
        n_old[LANE_B]   = r_s1_pix.in_blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_mode <= r_s1_mode;
        r_s2_pix  <= r_s1_pix;
        for (int i = 0; i < NUM_CHAN; i++) begin
            r_s2_pa[i] <= PROD_W'({{COV_W{1'b0}}, n_paint[i]} * {{CHAN_W{1'b0}}, r_s1_c});
            r_s2_po[i] <= PROD_W'({{COV_W{1'b0}}, n_old[i]} * {{CHAN_W{1'b0}}, r_s1_inv});
        end
    end

    // Stage 3: add, drop the fraction and select by mode
    always_comb begin
        for (int i = 0; i < NUM_CHAN; i++) begin
            n_mix[i] = CHAN_W'(({1'b0, r_s2_pa[i]} + {1'b0, r_s2_po[i]}) >> CHAN_W);
        end
        unique case (r_s2_mode)
            MODE_FULL: begin
                n_o_pix.out_alpha = r_tgt_alpha;
                n_o_pix.out_red   = r_tgt_red;
                n_o_pix.out_green = r_tgt_green;
                n_o_pix.out_blue  = r_tgt_blue;
            end
            MODE_PASS: begin
                n_o_pix.out_alpha = r_s2_pix.in_alpha;
                n_o_pix.out_red   = r_s2_pix.in_red;
                n_o_pix.out_green = r_s2_pix.in_green;
                n_o_pix.out_blue  = r_s2_pix.in_blue;
            end
            MODE_CLEAR: begin
                // old alpha is zero, so the alpha lane gives (255*c) >> 8
                n_o_pix.out_alpha = n_mix[LANE_A];
                n_o_pix.out_red   = r_tgt_red;
                n_o_pix.out_green = r_tgt_green;
                n_o_pix.out_blue  = r_tgt_blue;
            end
            MODE_MIX: begin
                n_o_pix.out_alpha = n_mix[LANE_A];
                n_o_pix.out_red   = n_mix[LANE_R];
                n_o_pix.out_green = n_mix[LANE_G];
                n_o_pix.out_blue  = n_mix[LANE_B];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_pix <= n_o_pix;
    end

    assign o_strobe = r_o_vld;
    assign o_pix    = r_o_pix;

endmodule
